// ===== hdl/rational_sum_accumulator_core_assert.svh =====
// assertion macros shared by the accumulator modules
`ifndef RATIONAL_SUM_ACCUMULATOR_CORE_ASSERT_SVH
`define RATIONAL_SUM_ACCUMULATOR_CORE_ASSERT_SVH
// implication checked on every rising clock edge outside reset
`define RSA_ASSERT_IMP(label, clk, rst, lhs, rhs, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) else $error(msg);
// next-cycle implication checked outside reset
`define RSA_ASSERT_NEXT(label, clk, rst, lhs, rhs, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) else $error(msg);
`endif

// ===== hdl/rsa_pkg.sv =====
// shared types and constants of the rational sum accumulator
`timescale 1ns / 1ps
`default_nettype none
package rsa_pkg;
   localparam int VALUE_WIDTH_DEFAULT = 32;
   localparam int WIDE = 64;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIV_IN,
      ST_MUL,
      ST_COMBINE,
      ST_GCD,
      ST_DIV_NUM,
      ST_DIV_DEN,
      ST_SPLIT,
      ST_COMMIT,
      ST_OUTPUT
   } state_type;

   typedef enum logic [2:0] {
      DIV_SRC_INPUT,
      DIV_SRC_GCD,
      DIV_SRC_NUM,
      DIV_SRC_DEN,
      DIV_SRC_SPLIT
   } div_src_type;

   typedef struct packed {
      logic        load;
      logic        mul_step;
      logic        combine;
      logic        div_start;
      div_src_type div_src;
      logic        div_take;
      logic        gcd_swap;
      logic        commit;
   } cmd_type;

   typedef struct packed {
      logic div_busy;
      logic div_done;
      logic mul_done;
      logic gcd_zero;
   } status_type;
endpackage
`default_nettype wire

// ===== hdl/rational_sum_accumulator_core.sv =====
// top level of the rational sum accumulator
// time from request accept to rsp_tvalid grows with the number of gcd steps
// throughput: one request at a time; next accepted the cycle after the result is registered
// the shift-add multiplier takes one bit of d per step; each division is started, runs busy, then is taken or swapped
// reset: synchronous, active high; sum clears to +0/1 and overflow clears
// result waits in the output register while the next request is worked on; commit stalls on it
`timescale 1ns / 1ps
`default_nettype none
module rational_sum_accumulator_core #(
   parameter int VALUE_WIDTH = rsa_pkg::VALUE_WIDTH_DEFAULT
) (
   input  wire          clock,
   input  wire          reset,
   input  wire          req_tvalid,
   output logic         req_tready,
   input  wire  [63:0]  req_tdata,  // numerator_in[31:0], denominator_in[62:32], pad
   input  wire          req_tuser,  // start_new
   output logic         rsp_tvalid,
   input  wire          rsp_tready,
   output logic [95:0]  rsp_tdata,  // whole_part, fraction_numerator, fraction_denominator
   output logic [1:0]   rsp_tuser   // negative, overflow
);
   rsa_pkg::cmd_type    cmd;
   rsa_pkg::status_type status;
   logic                req_fire;
   logic                neg, ovf;
   logic [30:0]         whole, fnum, fden;

   assign req_fire = req_tvalid && req_tready;

   // sequencer
   rsa_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_fire   (req_fire),
      .req_ready  (req_tready),
      .rsp_valid  (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // arithmetic
   rsa_datapath #(.VALUE_WIDTH(VALUE_WIDTH)) u_dp (
      .clock           (clock),
      .reset           (reset),
      .req_start_new   (req_tuser),
      .req_numerator   (req_tdata[31:0]),
      .req_denominator (req_tdata[62:32]),
      .cmd             (cmd),
      .status          (status),
      .rsp_negative    (neg),
      .rsp_whole       (whole),
      .rsp_fnum        (fnum),
      .rsp_fden        (fden),
      .rsp_overflow    (ovf)
   );

   // output fields come from the result register loaded at commit
   assign rsp_tdata = {3'b000, fden, fnum, whole};
   assign rsp_tuser = {ovf, neg};
endmodule
`default_nettype wire

// ===== hdl/rsa_ctrl.sv =====
// sequencer of the accumulator
`timescale 1ns / 1ps
`default_nettype none
`include "rational_sum_accumulator_core_assert.svh"
module rsa_ctrl (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_fire,
   output logic                req_ready,
   output logic                rsp_valid,
   input  wire                 rsp_tready,
   input  rsa_pkg::status_type status,
   output rsa_pkg::cmd_type    cmd
);
   rsa_pkg::state_type state_ff, state_in;
   logic               rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rsa_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd          = '0;
      cmd.div_src  = rsa_pkg::DIV_SRC_INPUT;
      req_ready    = 1'b0;
      if (rsp_valid_ff && rsp_tready) rsp_valid_in = 1'b0;
      case (state_ff)
         rsa_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_fire) begin
               cmd.load = 1'b1;
               state_in = rsa_pkg::ST_DIV_IN;
            end
         end
         rsa_pkg::ST_DIV_IN: begin
            cmd.div_start = 1'b1;
            cmd.div_src   = rsa_pkg::DIV_SRC_INPUT;
            state_in      = rsa_pkg::ST_MUL;
         end
         rsa_pkg::ST_MUL: begin
            cmd.div_src = rsa_pkg::DIV_SRC_INPUT;
            if (status.div_done) begin
               cmd.div_take = 1'b1;
            end else if (!status.div_busy) begin
               if (status.mul_done) state_in = rsa_pkg::ST_COMBINE;
               else cmd.mul_step = 1'b1;
            end
         end
         rsa_pkg::ST_COMBINE: begin
            cmd.combine = 1'b1;
            state_in    = rsa_pkg::ST_GCD;
         end
         rsa_pkg::ST_GCD: begin
            cmd.div_src = rsa_pkg::DIV_SRC_GCD;
            if (status.div_done) begin
               cmd.gcd_swap = 1'b1;
            end else if (!status.div_busy) begin
               if (status.gcd_zero) begin
                  cmd.div_start = 1'b1;
                  cmd.div_src   = rsa_pkg::DIV_SRC_NUM;
                  state_in      = rsa_pkg::ST_DIV_NUM;
               end else begin
                  cmd.div_start = 1'b1;
               end
            end
         end
         rsa_pkg::ST_DIV_NUM: begin
            cmd.div_src = rsa_pkg::DIV_SRC_NUM;
            if (status.div_done) begin
               cmd.div_take  = 1'b1;
               state_in      = rsa_pkg::ST_DIV_DEN;
            end
         end
         rsa_pkg::ST_DIV_DEN: begin
            cmd.div_src = rsa_pkg::DIV_SRC_DEN;
            if (status.div_done) begin
               cmd.div_take = 1'b1;
               state_in     = rsa_pkg::ST_SPLIT;
            end else if (!status.div_busy) begin
               cmd.div_start = 1'b1;
            end
         end
         rsa_pkg::ST_SPLIT: begin
            cmd.div_src = rsa_pkg::DIV_SRC_SPLIT;
            if (status.div_done) begin
               cmd.div_take = 1'b1;
               state_in     = rsa_pkg::ST_COMMIT;
            end else if (!status.div_busy) begin
               cmd.div_start = 1'b1;
            end
         end
         rsa_pkg::ST_COMMIT: begin
            if (!rsp_valid_ff) begin
               cmd.commit   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = rsa_pkg::ST_IDLE;
            end
         end
         default: state_in = rsa_pkg::ST_IDLE;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

   `RSA_ASSERT_IMP(a_ready_idle, clock, reset, req_ready, state_ff == rsa_pkg::ST_IDLE, "ready outside idle")
   `RSA_ASSERT_NEXT(a_commit_valid, clock, reset, cmd.commit, rsp_valid_ff, "commit without response")
   `RSA_ASSERT_IMP(a_commit_free, clock, reset, cmd.commit, !rsp_valid_ff, "commit over pending response")
endmodule
`default_nettype wire

// ===== hdl/rsa_datapath.sv =====
// arithmetic datapath: shift-add multiplier, restoring divider, sum registers
`timescale 1ns / 1ps
`default_nettype none
`include "rational_sum_accumulator_core_assert.svh"
module rsa_datapath #(
   parameter int VALUE_WIDTH = rsa_pkg::VALUE_WIDTH_DEFAULT
) (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_start_new,
   input  wire  [31:0]         req_numerator,
   input  wire  [30:0]         req_denominator,
   input  rsa_pkg::cmd_type    cmd,
   output rsa_pkg::status_type status,
   output logic                rsp_negative,
   output logic [30:0]         rsp_whole,
   output logic [30:0]         rsp_fnum,
   output logic [30:0]         rsp_fden,
   output logic                rsp_overflow
);
   localparam int W = rsa_pkg::WIDE;
   localparam logic [W-1:0] MAG_MAX = (W'(1) << (VALUE_WIDTH - 1)) - W'(1);

   // committed sum
   logic         neg_ff, neg_in;
   logic [W-1:0] whole_ff, whole_in, num_ff, num_in, den_ff, den_in;
   logic         ovf_ff, ovf_in;
   // result register, holds the reported sum while the next request is worked on
   logic         out_neg_ff, out_ovf_ff;
   logic [30:0]  out_whole_ff, out_num_ff, out_den_ff;
   // item working registers
   logic         in_neg_ff;
   logic [W-1:0] mag_ff, d_ff, q_ff, f_ff;
   logic [W-1:0] p1_ff, p2_ff, dd_ff;   // num*d, f*den, den*d
   logic [5:0]   mul_cnt_ff;
   logic         mul_done_ff;
   logic         wneg_ff;
   logic [W-1:0] wwhole_ff, wnum_ff, a_ff, b_ff, rden_ff;
   // divider
   logic [W-1:0] dv_q_ff, dv_r_ff, dv_d_ff;
   logic [6:0]   dv_cnt_ff;
   logic         dv_busy_ff, dv_done_ff;
   logic [W-1:0] dv_num, dv_den;
   logic [W:0]   dv_trial;
   logic [W-1:0] dv_rsh;

   always_comb begin
      case (cmd.div_src)
         rsa_pkg::DIV_SRC_INPUT: begin dv_num = mag_ff;  dv_den = d_ff;    end
         rsa_pkg::DIV_SRC_GCD:   begin dv_num = a_ff;    dv_den = b_ff;    end
         rsa_pkg::DIV_SRC_NUM:   begin dv_num = wnum_ff; dv_den = a_ff;    end
         rsa_pkg::DIV_SRC_DEN:   begin dv_num = dd_ff;   dv_den = a_ff;    end
         rsa_pkg::DIV_SRC_SPLIT: begin dv_num = wnum_ff; dv_den = rden_ff; end
         default:                begin dv_num = mag_ff;  dv_den = d_ff;    end
      endcase
   end

   assign dv_rsh   = {dv_r_ff[W-2:0], dv_q_ff[W-1]};
   assign dv_trial = {1'b0, dv_rsh} - {1'b0, dv_d_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_busy_ff <= 1'b0;
         dv_done_ff <= 1'b0;
      end else if (cmd.div_start) begin
         dv_busy_ff <= 1'b1;
         dv_done_ff <= 1'b0;
         dv_cnt_ff  <= 7'(W);
         dv_q_ff    <= dv_num;
         dv_r_ff    <= '0;
         dv_d_ff    <= dv_den;
      end else if (dv_busy_ff) begin
         if (!dv_trial[W]) begin
            dv_r_ff <= dv_trial[W-1:0];
            dv_q_ff <= {dv_q_ff[W-2:0], 1'b1};
         end else begin
            dv_r_ff <= dv_rsh;
            dv_q_ff <= {dv_q_ff[W-2:0], 1'b0};
         end
         dv_cnt_ff <= dv_cnt_ff - 7'd1;
         if (dv_cnt_ff == 7'd1) begin
            dv_busy_ff <= 1'b0;
            dv_done_ff <= 1'b1;
         end
      end else if (cmd.div_take || cmd.gcd_swap) begin
         dv_done_ff <= 1'b0;
      end
   end

   assign status.div_busy = dv_busy_ff;
   assign status.div_done = dv_done_ff;
   assign status.mul_done = mul_done_ff;
   assign status.gcd_zero = (b_ff == '0);

   // multiplier operands, all three products share one shift-add pass
   logic [W-1:0] base_num, base_den;
   logic         ld_clear;
   assign ld_clear = req_start_new;

   logic signed [W:0] iw, fn, iw2, fn2;
   logic [W-1:0] dd_comb;

   always_comb begin
      iw  = $signed({1'b0, whole_ff}) - $signed({1'b0, q_ff});
      fn  = $signed({1'b0, p1_ff}) - $signed({1'b0, p2_ff});
      iw2 = iw;
      fn2 = fn;
      if (iw > 0 && fn < 0) begin
         iw2 = iw - 1;
         fn2 = fn + $signed({1'b0, dd_ff});
      end else if (iw < 0 && fn > 0) begin
         iw2 = iw + 1;
         fn2 = fn - $signed({1'b0, dd_ff});
      end
   end
   assign dd_comb = dd_ff;
   assign base_num = num_ff;
   assign base_den = den_ff;

   // q_ff holds the split quotient and the divider the split remainder at commit
   logic [W-1:0] fin_whole;
   logic [W-1:0] fin_num;
   logic         fin_neg;
   logic         fin_ovf;
   assign fin_whole = wwhole_ff + q_ff;
   assign fin_num   = dv_r_ff;
   assign fin_neg   = (fin_whole == '0 && fin_num == '0) ? 1'b0 : wneg_ff;
   assign fin_ovf   = fin_whole > MAG_MAX || fin_num > MAG_MAX || rden_ff > MAG_MAX;

   always_comb begin
      neg_in   = neg_ff;
      whole_in = whole_ff;
      num_in   = num_ff;
      den_in   = den_ff;
      ovf_in   = ovf_ff;
      if (cmd.load && ld_clear) begin
         neg_in   = 1'b0;
         whole_in = '0;
         num_in   = '0;
         den_in   = W'(1);
         ovf_in   = 1'b0;
      end
      if (cmd.commit) begin
         if (fin_ovf) ovf_in = 1'b1;
         else begin
            neg_in   = fin_neg;
            whole_in = fin_whole;
            num_in   = fin_num;
            den_in   = rden_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         neg_ff   <= 1'b0;
         whole_ff <= '0;
         num_ff   <= '0;
         den_ff   <= W'(1);
         ovf_ff   <= 1'b0;
      end else begin
         neg_ff   <= neg_in;
         whole_ff <= whole_in;
         num_ff   <= num_in;
         den_ff   <= den_in;
         ovf_ff   <= ovf_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_neg_ff   <= 1'b0;
         out_whole_ff <= '0;
         out_num_ff   <= '0;
         out_den_ff   <= 31'd1;
         out_ovf_ff   <= 1'b0;
      end else if (cmd.commit) begin
         out_neg_ff   <= neg_in;
         out_whole_ff <= whole_in[30:0];
         out_num_ff   <= num_in[30:0];
         out_den_ff   <= den_in[30:0];
         out_ovf_ff   <= ovf_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_done_ff <= 1'b0;
         mul_cnt_ff  <= '0;
      end else if (cmd.load) begin
         in_neg_ff   <= req_numerator[31];
         mag_ff      <= W'(req_numerator[31] ? 32'(-req_numerator) : req_numerator);
         d_ff        <= (req_denominator == '0) ? W'(1) : W'(req_denominator);
         p1_ff       <= '0;
         p2_ff       <= '0;
         dd_ff       <= '0;
         mul_cnt_ff  <= '0;
         mul_done_ff <= 1'b0;
      end else begin
         if (cmd.div_take) begin
            case (cmd.div_src)
               rsa_pkg::DIV_SRC_INPUT: begin q_ff <= dv_q_ff; f_ff <= dv_r_ff; end
               rsa_pkg::DIV_SRC_NUM:   begin wnum_ff <= dv_q_ff; end
               rsa_pkg::DIV_SRC_DEN:   begin rden_ff <= dv_q_ff; end
               rsa_pkg::DIV_SRC_SPLIT: begin q_ff <= dv_q_ff; end
               default:                begin q_ff <= q_ff; end
            endcase
         end
         if (cmd.mul_step) begin
            // one bit position per cycle while mul_step is given: bit of d for num*d and den*d, bit of den for f*den
            if (d_ff[mul_cnt_ff]) begin
               p1_ff <= p1_ff + (base_num << mul_cnt_ff);
               dd_ff <= dd_ff + (base_den << mul_cnt_ff);
            end
            if (base_den[mul_cnt_ff])
               p2_ff <= p2_ff + (f_ff << mul_cnt_ff);
            mul_cnt_ff <= mul_cnt_ff + 6'd1;
            if (mul_cnt_ff == 6'd31) mul_done_ff <= 1'b1;
         end
         if (cmd.combine) begin
            if (in_neg_ff == neg_ff) begin
               wneg_ff   <= neg_ff;
               wwhole_ff <= whole_ff + q_ff;
               wnum_ff   <= p1_ff + p2_ff;
               a_ff      <= p1_ff + p2_ff;
            end else begin
               wneg_ff   <= (iw2 < 0 || fn2 < 0) ? !neg_ff : neg_ff;
               wwhole_ff <= iw2[W] ? W'(-iw2) : iw2[W-1:0];
               wnum_ff   <= fn2[W] ? W'(-fn2) : fn2[W-1:0];
               a_ff      <= fn2[W] ? W'(-fn2) : fn2[W-1:0];
            end
            b_ff <= dd_comb;
         end
         if (cmd.gcd_swap) begin
            a_ff <= b_ff;
            b_ff <= dv_r_ff;
         end
         if (cmd.div_start && cmd.div_src == rsa_pkg::DIV_SRC_NUM && a_ff == '0)
            a_ff <= W'(1);
      end
   end

   assign rsp_negative = out_neg_ff;
   assign rsp_whole    = out_whole_ff;
   assign rsp_fnum     = out_num_ff;
   assign rsp_fden     = out_den_ff;
   assign rsp_overflow = out_ovf_ff;

   `RSA_ASSERT_IMP(a_den_nz, clock, reset, 1'b1, den_ff != '0, "zero sum denominator")
   `RSA_ASSERT_IMP(a_zero_pos, clock, reset, whole_ff == '0 && num_ff == '0, !neg_ff, "negative zero")
   `RSA_ASSERT_IMP(a_proper, clock, reset, 1'b1, num_ff < den_ff, "improper fraction")
endmodule
`default_nettype wire

// ===== verif/testbench.sv =====
// self-checking testbench of the rational sum accumulator core
`timescale 1ns / 1ps
`default_nettype none

typedef struct {
   bit          negative;
   logic [30:0] whole_part;
   logic [30:0] fraction_numerator;
   logic [30:0] fraction_denominator;
   bit          overflow;
} rational_sum_type;

// running-sum predictor and queue of sums still to come out of the block
class rational_sum_board;
   localparam logic [63:0] PART_MAX = (64'd1 << (rsa_pkg::VALUE_WIDTH_DEFAULT - 1)) - 64'd1;

   bit          acc_negative;
   logic [63:0] acc_whole;
   logic [63:0] acc_numerator;
   logic [63:0] acc_denominator;
   bit          acc_overflow;
   rational_sum_type pending_sums[$];
   int          error_count;

   function new();
      acc_negative    = 0;
      acc_whole       = 0;
      acc_numerator   = 0;
      acc_denominator = 1;
      acc_overflow    = 0;
      error_count     = 0;
   endfunction

   // fold one accepted request into the running sum and queue the result
   function void note_request(bit start_new, logic [31:0] raw, logic [30:0] den);
      bit          in_neg;
      bit          neg;
      logic [63:0] mag, d, q, f, dd, whole, num, a, b, t;
      longint      iw, fn;
      rational_sum_type s;
      if (start_new) begin
         acc_negative    = 0;
         acc_whole       = 0;
         acc_numerator   = 0;
         acc_denominator = 1;
         acc_overflow    = 0;
      end
      in_neg = raw[31];
      mag = {32'd0, in_neg ? (~raw + 32'd1) : raw};
      d = {33'd0, den};
      if (d == 0) d = 1;
      q = mag / d;
      f = mag % d;
      dd = acc_denominator * d;
      if (in_neg == acc_negative) begin
         neg = acc_negative;
         whole = acc_whole + q;
         num = acc_numerator * d + f * acc_denominator;
      end else begin
         iw = longint'(acc_whole) - longint'(q);
         fn = longint'(acc_numerator * d) - longint'(f * acc_denominator);
         // borrow a whole unit when whole and fraction differ in sign
         if (iw > 0 && fn < 0) begin
            iw = iw - 1;
            fn = fn + longint'(dd);
         end else if (iw < 0 && fn > 0) begin
            iw = iw + 1;
            fn = fn - longint'(dd);
         end
         neg = (iw < 0 || fn < 0) ? !acc_negative : acc_negative;
         whole = (iw < 0) ? -iw : iw;
         num = (fn < 0) ? -fn : fn;
      end
      a = num;
      b = dd;
      while (b != 0) begin
         t = a % b;
         a = b;
         b = t;
      end
      if (a == 0) a = 1;
      num = num / a;
      dd = dd / a;
      whole = whole + num / dd;
      num = num % dd;
      if (whole == 0 && num == 0) neg = 0;
      if (whole > PART_MAX || num > PART_MAX || dd > PART_MAX) begin
         acc_overflow = 1;
      end else begin
         acc_negative    = neg;
         acc_whole       = whole;
         acc_numerator   = num;
         acc_denominator = dd;
      end
      s.negative             = acc_negative;
      s.whole_part           = acc_whole[30:0];
      s.fraction_numerator   = acc_numerator[30:0];
      s.fraction_denominator = acc_denominator[30:0];
      s.overflow             = acc_overflow;
      pending_sums.push_back(s);
   endfunction

   function void check_sum(logic [95:0] tdata, logic [1:0] tuser);
      rational_sum_type s;
      if (pending_sums.size() == 0) begin
         $error("sum came out with none expected");
         error_count++;
         return;
      end
      s = pending_sums.pop_front();
      if (tuser[0] !== s.negative) begin
         $error("negative: expected %0d actual %0d", s.negative, tuser[0]);
         error_count++;
      end
      if (tdata[30:0] !== s.whole_part) begin
         $error("whole_part: expected %0d actual %0d", s.whole_part, tdata[30:0]);
         error_count++;
      end
      if (tdata[61:31] !== s.fraction_numerator) begin
         $error("fraction_numerator: expected %0d actual %0d",
                s.fraction_numerator, tdata[61:31]);
         error_count++;
      end
      if (tdata[92:62] !== s.fraction_denominator) begin
         $error("fraction_denominator: expected %0d actual %0d",
                s.fraction_denominator, tdata[92:62]);
         error_count++;
      end
      if (tuser[1] !== s.overflow) begin
         $error("overflow: expected %0d actual %0d", s.overflow, tuser[1]);
         error_count++;
      end
   endfunction
endclass

module testbench;
   localparam longint CYCLE_LIMIT = 80_000_000;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;   // numerator_in[31:0], denominator_in[62:32], pad
   logic        req_tuser = 0;    // start_new
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [95:0] rsp_tdata;        // whole_part, fraction_numerator, fraction_denominator, pad
   logic [1:0]  rsp_tuser;        // negative, overflow

   rational_sum_board board = new();
   int          sender_idle_pct = 0;
   int          receiver_idle_pct = 0;
   bit          hold_request = 0;
   longint      cycle_count = 0;

   rational_sum_accumulator_core dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // receiver: random back-pressure, plus a long hold-off when asked
   initial begin
      int hold_left;
      hold_left = 0;
      forever begin
         if (hold_request) begin
            hold_left = 30000;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            rsp_tready <= 0;
            hold_left--;
         end else begin
            rsp_tready <= ($urandom_range(99) >= receiver_idle_pct);
         end
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready)
            board.check_sum(rsp_tdata, rsp_tuser);
      end
   end

   // offer one request and wait for it to be taken, idling first at random
   task automatic send_fraction(bit start_new, logic [31:0] num, logic [30:0] den);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 0;
         @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata  <= {1'b0, den, num};
      req_tuser  <= start_new;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.note_request(start_new, num, den);
   endtask

   task automatic drain_sums();
      req_tvalid <= 0;
      @(posedge clock);
      while (board.pending_sums.size() != 0) @(posedge clock);
   endtask

   // mostly small values so sums stay exact, some wide ones for overflow and bit coverage
   task automatic send_random_fraction(bit start_new);
      logic [31:0] num;
      logic [30:0] den;
      int          pick;
      pick = $urandom_range(19);
      if (pick < 12) begin
         num = 32'($signed($urandom_range(40)) - 20);
         den = 31'($urandom_range(12, 1));
      end else if (pick < 16) begin
         num = 32'($signed($urandom_range(65535)) - 32768);
         den = 31'($urandom_range(65535, 1));
      end else if (pick < 19) begin
         num = $urandom;
         den = 31'($urandom);
      end else begin
         num = ($urandom_range(1)) ? 32'h8000_0000 : 32'h7FFF_FFFF;
         den = ($urandom_range(1)) ? 31'd0 : 31'h7FFF_FFFF;
      end
      send_fraction(start_new, num, den);
   endtask

   initial begin
      int n;
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: field extremes, zero denominator, sign folding, zero sum
      send_fraction(1, 32'd1, 31'd2);
      send_fraction(0, 32'd1, 31'd3);
      send_fraction(0, -32'sd5, 31'd6);          // opposite signs, lands on zero
      send_fraction(0, -32'sd7, 31'd4);          // sign flips negative
      send_fraction(0, 32'd3, 31'd2);            // whole parts cancel, sum stays negative
      send_fraction(0, 32'd0, 31'd0);            // zero denominator taken as one
      send_fraction(1, 32'h8000_0000, 31'd1);
      send_fraction(0, 32'h7FFF_FFFF, 31'd1);
      send_fraction(0, 32'd1, 31'h7FFF_FFFF);
      send_fraction(1, 32'h7FFF_FFFF, 31'h7FFF_FFFF);
      send_fraction(1, 32'h7FFF_FFFF, 31'd1);
      send_fraction(0, 32'h7FFF_FFFF, 31'd1);    // whole part too large, sticky flag
      send_fraction(0, -32'sd1, 31'd1);          // flag stays set
      send_fraction(1, 32'd1, 31'h7FFF_FFFF);
      send_fraction(0, 32'd1, 31'h7FFF_FFFE);    // denominator too large
      send_fraction(1, 32'h8000_0000, 31'h7FFF_FFFF);
      send_fraction(0, 32'h8000_0000, 31'd3);
      send_fraction(1, 32'd0, 31'h7FFF_FFFF);    // clears flag, zero sum
      send_fraction(0, 32'hFFFF_FFFF, 31'h5555_5555);
      drain_sums();

      // random: runs of related fractions, each opened by a fresh start
      for (n = 0; n < 1750; n++) begin
         if (n == 0) begin
            sender_idle_pct = 6;
            receiver_idle_pct = 52;
         end else if (n == 580) begin
            sender_idle_pct = 52;
            receiver_idle_pct = 6;
         end else if (n == 1160) begin
            sender_idle_pct = 0;
            receiver_idle_pct = 0;
         end
         if (n == 300 || n == 1400) hold_request = 1;
         if (n == 900) drain_sums();
         send_random_fraction($urandom_range(7) == 0);
      end

      drain_sums();
      repeat (8000) @(posedge clock);
      if (board.error_count == 0 && board.pending_sums.size() == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end
endmodule

`default_nettype wire

// ===== sim.f =====
+incdir+hdl
hdl/rsa_pkg.sv
hdl/rsa_ctrl.sv
hdl/rsa_datapath.sv
hdl/rational_sum_accumulator_core.sv
verif/testbench.sv
